/* src/rcp_pkg.sv */
`timescale 1ns / 1ps

package rcp_pkg;

  // Pulse window in microseconds that maps onto the full drive range.
  localparam int unsigned PULSE_LO  = 1000;
  localparam int unsigned PULSE_HI  = 2000;
  localparam int unsigned LEVEL_MAX = 255;

  // (pulse - PULSE_LO) * 510 / 1000 equals floor(d * 51 / 100) for d >= 0.
  // The division by 100 is a multiply by ceil(2^23 / 100) and a shift,
  // exact for every product below 91180; d * 51 never exceeds 50949.
  localparam int unsigned MAP_NUM   = 51;
  localparam int unsigned MAP_RECIP = 83887;
  localparam int unsigned MAP_MUL   = MAP_NUM * MAP_RECIP;
  localparam int unsigned MAP_SHIFT = 23;

  // Register reset values.
  localparam logic [7:0] DEADZONE_RST  = 8'd40;
  localparam logic [7:0] SLEW_STEP_RST = 8'd10;

  // Configuration register indexes.
  localparam logic CFG_DEADZONE  = 1'b0;
  localparam logic CFG_SLEW_STEP = 1'b1;

  typedef logic [14:0] pulse_t;
  typedef logic [7:0]  duty_t;
  typedef logic signed [8:0] level_t;

endpackage

/* src/rcp_if.sv */
`timescale 1ns / 1ps

// Input channel: one item carries both receiver pulse widths.
interface rcp_in_if import rcp_pkg::*;;
  logic   valid;
  logic   ready;
  pulse_t left_pulse_us;
  pulse_t right_pulse_us;

  modport source (output valid, output left_pulse_us, output right_pulse_us, input ready);
  modport sink   (input valid, input left_pulse_us, input right_pulse_us, output ready);
endinterface

// Result channel: one item carries the four H-bridge duties.
interface rcp_out_if import rcp_pkg::*;;
  logic  valid;
  logic  ready;
  duty_t left_forward_duty;
  duty_t left_reverse_duty;
  duty_t right_forward_duty;
  duty_t right_reverse_duty;

  modport source (output valid, output left_forward_duty, output left_reverse_duty,
                  output right_forward_duty, output right_reverse_duty, input ready);
  modport sink   (input valid, input left_forward_duty, input left_reverse_duty,
                  input right_forward_duty, input right_reverse_duty, output ready);
endinterface

/* src/rc_pulse_to_hbridge_ramp.sv */
`timescale 1ns / 1ps

// Channel   Direction  Content
// in_item   sink       left_pulse_us, right_pulse_us (15 bit each)
// out_item  source     left/right forward and reverse duty (8 bit each)
// cfg_*     write      index 0 deadzone, index 1 slew step (8 bit data)
//
// One item per cycle is sustained while the output is not stalled. The
// pulse-to-target mapping is registered, then the slew and duty split land
// in the output register. A full target stage and the output register hold
// while the output is stalled. Synchronous reset clears both levels, the
// valid flags and loads the register defaults (deadzone 40, slew step 10).
module rc_pulse_to_hbridge_ramp
  import rcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  rcp_in_if.sink       in_item,
  rcp_out_if.source    out_item,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_data
);

  // Map one pulse to a target level, with saturation and deadzone.
  function automatic level_t pulse_to_target(input pulse_t p, input logic [7:0] dz);
    logic [9:0]        d;
    logic [31:0]       prod;
    logic [8:0]        q;
    logic signed [9:0] t_wide;
    level_t            t;
    logic [8:0]        mag;
    d      = '0;
    prod   = '0;
    q      = '0;
    t_wide = '0;
    if (p <= 15'(PULSE_LO)) begin
      t = -9'sd255;
    end else if (p >= 15'(PULSE_HI)) begin
      t = 9'sd255;
    end else begin
      d      = 10'(p - 15'(PULSE_LO));
      prod   = 32'(d) * 32'(MAP_MUL);
      q      = prod[MAP_SHIFT +: 9];
      t_wide = $signed({1'b0, q}) - 10'sd255;
      t      = t_wide[8:0];
    end
    mag = t[8] ? 9'(-t) : 9'(t);
    if (mag < {1'b0, dz}) begin
      t = '0;
    end
    return t;
  endfunction

  // Move a level toward its target by at most one slew step.
  function automatic level_t slew(input level_t lvl, input level_t tgt, input logic [7:0] step);
    logic signed [9:0] up;
    logic signed [9:0] dn;
    level_t            res;
    up  = 10'(lvl) + $signed({2'b00, step});
    dn  = 10'(lvl) - $signed({2'b00, step});
    res = lvl;
    if (lvl < tgt) begin
      res = (up > 10'(tgt)) ? tgt : up[8:0];
    end else if (lvl > tgt) begin
      res = (dn < 10'(tgt)) ? tgt : dn[8:0];
    end
    return res;
  endfunction

  logic [7:0] deadzone_r;
  logic [7:0] slew_step_r;

  logic   tgt_valid_r;
  level_t left_tgt_r;
  level_t right_tgt_r;
  level_t left_tgt_nxt;
  level_t right_tgt_nxt;

  level_t left_level_r;
  level_t right_level_r;
  level_t left_level_nxt;
  level_t right_level_nxt;

  logic  out_valid_r;
  duty_t lf_duty_r;
  duty_t lr_duty_r;
  duty_t rf_duty_r;
  duty_t rr_duty_r;

  logic advance;
  logic in_fire;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r  <= DEADZONE_RST;
      slew_step_r <= SLEW_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEADZONE:  deadzone_r  <= cfg_data;
        CFG_SLEW_STEP: slew_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the target stage moves on whenever the output slot is free.
  assign advance          = tgt_valid_r && (!out_valid_r || out_item.ready);
  assign in_item.ready    = !tgt_valid_r || advance;
  assign in_fire          = in_item.valid && in_item.ready;

  // Targets; a lost signal on either channel zeroes both.
  always_comb begin
    left_tgt_nxt  = '0;
    right_tgt_nxt = '0;
    if (in_item.left_pulse_us != '0 && in_item.right_pulse_us != '0) begin
      left_tgt_nxt  = pulse_to_target(in_item.left_pulse_us, deadzone_r);
      right_tgt_nxt = pulse_to_target(in_item.right_pulse_us, deadzone_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_valid_r <= 1'b0;
    end else if (in_item.ready) begin
      tgt_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      left_tgt_r  <= left_tgt_nxt;
      right_tgt_r <= right_tgt_nxt;
    end
  end

  // Slew limited motor levels.
  always_comb begin
    left_level_nxt  = slew(left_level_r, left_tgt_r, slew_step_r);
    right_level_nxt = slew(right_level_r, right_tgt_r, slew_step_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_level_r  <= '0;
      right_level_r <= '0;
    end else if (advance) begin
      left_level_r  <= left_level_nxt;
      right_level_r <= right_level_nxt;
    end
  end

  // Output register with the forward / reverse split.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lf_duty_r <= (left_level_nxt > 0)   ? left_level_nxt[7:0]     : '0;
      lr_duty_r <= (left_level_nxt < 0)   ? 8'(-left_level_nxt)     : '0;
      rf_duty_r <= (right_level_nxt > 0)  ? right_level_nxt[7:0]    : '0;
      rr_duty_r <= (right_level_nxt < 0)  ? 8'(-right_level_nxt)    : '0;
    end
  end

  assign out_item.valid              = out_valid_r;
  assign out_item.left_forward_duty  = lf_duty_r;
  assign out_item.left_reverse_duty  = lr_duty_r;
  assign out_item.right_forward_duty = rf_duty_r;
  assign out_item.right_reverse_duty = rr_duty_r;

endmodule

/* dv/rc_pulse_to_hbridge_ramp_tb.sv */
`timescale 1ns / 1ps

module rc_pulse_to_hbridge_ramp_tb;
  import rcp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 90;
  localparam int unsigned NUM_PHASES  = 9;
  localparam int unsigned LONG_STALL  = 300;
  localparam int unsigned DRAIN_WAIT  = 10;

  typedef struct packed {
    pulse_t left;
    pulse_t right;
  } pulse_pair_t;

  typedef struct packed {
    duty_t lf;
    duty_t lr;
    duty_t rf;
    duty_t rr;
  } duty_set_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  rcp_in_if  in_ch ();
  rcp_out_if out_ch ();

  rc_pulse_to_hbridge_ramp dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Stimulus and expected duties flow through these queues.
  pulse_pair_t pending_pulses[$];
  duty_set_t   expected_duties[$];

  // Shadow copy of the block's registers and motor levels.
  logic [7:0] dz_reg;
  logic [7:0] step_reg;
  level_t     left_lvl;
  level_t     right_lvl;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          sender_hold;
  int unsigned recv_hold_req;
  int unsigned recv_hold_left;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Linear pulse mapping with C-style truncating division, then saturation.
  function automatic int pulse_target(pulse_t p);
    longint t;
    t = (longint'(p) - longint'(PULSE_LO)) * 2 * longint'(LEVEL_MAX)
        / (longint'(PULSE_HI) - longint'(PULSE_LO)) - longint'(LEVEL_MAX);
    if (t > longint'(LEVEL_MAX)) t = longint'(LEVEL_MAX);
    if (t < -longint'(LEVEL_MAX)) t = -longint'(LEVEL_MAX);
    return int'(t);
  endfunction

  function automatic int deadzone_gate(int t);
    int mag;
    mag = (t < 0) ? -t : t;
    return (mag < int'(dz_reg)) ? 0 : t;
  endfunction

  // Move a level toward its target by at most the slew step.
  function automatic int slew_toward(int lvl, int tgt);
    int step;
    step = int'(step_reg);
    if (lvl < tgt) begin
      lvl = lvl + step;
      if (lvl > tgt) lvl = tgt;
    end else if (lvl > tgt) begin
      lvl = lvl - step;
      if (lvl < tgt) lvl = tgt;
    end
    return lvl;
  endfunction

  // Advance the shadow levels by one tick and return the four duties.
  function automatic duty_set_t predict_duties(pulse_pair_t item);
    int        tl;
    int        tr;
    duty_set_t d;
    tl = 0;
    tr = 0;
    if (item.left != '0 && item.right != '0) begin
      tl = deadzone_gate(pulse_target(item.left));
      tr = deadzone_gate(pulse_target(item.right));
    end
    left_lvl  = level_t'(slew_toward(int'(left_lvl), tl));
    right_lvl = level_t'(slew_toward(int'(right_lvl), tr));
    d.lf = (left_lvl > 0) ? duty_t'(left_lvl) : '0;
    d.lr = (left_lvl < 0) ? duty_t'(-left_lvl) : '0;
    d.rf = (right_lvl > 0) ? duty_t'(right_lvl) : '0;
    d.rr = (right_lvl < 0) ? duty_t'(-right_lvl) : '0;
    return d;
  endfunction

  task automatic add_item(int unsigned l, int unsigned r);
    pulse_pair_t p;
    p.left  = pulse_t'(l);
    p.right = pulse_t'(r);
    pending_pulses.push_back(p);
  endtask

  // Mostly held stick positions with small jitter, plus signal loss and noise.
  task automatic queue_random(int unsigned n);
    int unsigned made;
    int unsigned kind;
    int unsigned run;
    int unsigned l;
    int unsigned r;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(99);
      if (kind < 6) begin
        case ($urandom_range(2))
          0: add_item(0, 0);
          1: add_item(0, $urandom_range(900, 2100));
          default: add_item($urandom_range(900, 2100), 0);
        endcase
        made++;
      end else if (kind < 12) begin
        add_item($urandom_range(32767), $urandom_range(32767));
        made++;
      end else begin
        l   = $urandom_range(900, 2100);
        r   = $urandom_range(900, 2100);
        run = $urandom_range(1, 24);
        for (int i = 0; i < run; i++) begin
          add_item(l + $urandom_range(4), r + $urandom_range(4));
        end
        made += run;
      end
    end
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DEADZONE) dz_reg = val;
    else step_reg = val;
  endtask

  // Wait until every item has been taken and every result delivered.
  task automatic wait_idle();
    while (pending_pulses.size() != 0 || in_ch.valid || expected_duties.size() != 0)
      @(posedge clk);
  endtask

  // Driver: offers pending items, holding valid until each one is taken.
  always @(posedge clk) begin : driver
    bit taken;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      taken = in_ch.valid && in_ch.ready;
      if (taken) begin
        expected_duties.push_back(predict_duties(pending_pulses[0]));
        void'(pending_pulses.pop_front());
      end
      if (in_ch.valid && !taken) begin
        // Keep offering the same item.
      end else if (pending_pulses.size() != 0 && !sender_hold &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid          <= 1'b1;
        in_ch.left_pulse_us  <= pending_pulses[0].left;
        in_ch.right_pulse_us <= pending_pulses[0].right;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each delivered item and decides the next ready.
  always @(posedge clk) begin : monitor
    duty_set_t got;
    duty_set_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.left_forward_duty, out_ch.left_reverse_duty,
                out_ch.right_forward_duty, out_ch.right_reverse_duty};
        if (expected_duties.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected item: lf=%0d lr=%0d rf=%0d rr=%0d",
                     got.lf, got.lr, got.rf, got.rr);
          mismatch_count++;
        end else begin
          want = expected_duties.pop_front();
          if (got.lf != want.lf || got.lr != want.lr ||
              got.rf != want.rf || got.rr != want.rr) begin
            if (mismatch_count < 10)
              $display({"mismatch: expected lf=%0d lr=%0d rf=%0d rr=%0d, ",
                        "got lf=%0d lr=%0d rf=%0d rr=%0d"},
                       want.lf, want.lr, want.rf, want.rr,
                       got.lf, got.lr, got.rf, got.rr);
            mismatch_count++;
          end
        end
      end
      // A long hold-off request is counted down here.
      if (recv_hold_req != 0) begin
        recv_hold_left = recv_hold_req;
        recv_hold_req  = 0;
      end
      if (recv_hold_left != 0) begin
        recv_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Run length guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sequencing of reset, directed items and the random phases.
  initial begin
    logic [7:0] phase_dz[NUM_PHASES];
    logic [7:0] phase_step[NUM_PHASES];
    in_ch.valid          = 1'b0;
    in_ch.left_pulse_us  = '0;
    in_ch.right_pulse_us = '0;
    out_ch.ready         = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_DEADZONE;
    cfg_data             = '0;
    dz_reg               = DEADZONE_RST;
    step_reg             = SLEW_STEP_RST;
    left_lvl             = '0;
    right_lvl            = '0;
    sender_hold          = 1'b0;
    recv_hold_req        = 0;
    recv_hold_left       = 0;
    mismatch_count       = 0;
    cycle_count          = 0;
    send_idle_pct        = 31;
    recv_idle_pct        = 66;

    // Settings per phase: extremes, a zero step that freezes the levels,
    // the reset values and one random pair.
    phase_dz   = '{8'd0,   8'd255, 8'd40, 8'd0, 8'd20, 8'd128, 8'd255, 8'd0, 8'd0};
    phase_step = '{8'd255, 8'd1,   8'd10, 8'd0, 8'd3,  8'd255, 8'd255, 8'd0, 8'd1};
    phase_dz[7]   = 8'($urandom_range(255));
    phase_step[7] = 8'($urandom_range(255));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset settings.
    add_item(0, 0);
    add_item(0, 1500);
    add_item(1500, 0);
    add_item(2000, 1000);
    add_item(2000, 1000);
    add_item(2000, 1000);
    add_item(32767, 1);
    add_item(30000, 30000);
    add_item(1000, 2000);
    add_item(999, 2001);
    add_item(1500, 1500);
    // Targets just inside and just outside the deadzone on each side.
    add_item(1580, 1422);
    add_item(1580, 1422);
    add_item(1578, 1424);
    add_item(1578, 1424);
    add_item(1, 32767);
    add_item(16384, 8191);
    add_item(21845, 10922);
    add_item(0, 0);
    add_item(2000, 2000);
    // Pulses whose scaled offset sits just below a multiple of 100.
    add_item(1949, 1049);
    add_item(1949, 1049);
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 31;
        recv_idle_pct = 66;
      end else if (ph < 6) begin
        send_idle_pct = 66;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_DEADZONE, phase_dz[ph]);
      write_reg(CFG_SLEW_STEP, phase_step[ph]);
      queue_random(PHASE_ITEMS);
      if (ph == 6) begin
        // Stall the receiver long enough to back the pipeline up.
        while (pending_pulses.size() > 60) @(posedge clk);
        recv_hold_req = LONG_STALL;
        // Then let the sender pause until everything has drained.
        while (pending_pulses.size() > 30) @(posedge clk);
        sender_hold = 1'b1;
        while (in_ch.valid || expected_duties.size() != 0) @(posedge clk);
        sender_hold = 1'b0;
      end
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_duties.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rcp_pkg.sv
src/rcp_if.sv
src/rc_pulse_to_hbridge_ramp.sv
dv/rc_pulse_to_hbridge_ramp_tb.sv
